@@ rtl/ssd_pkg.sv @@
// Shared widths, the set record and the back-end state type of the standard deviation block.
package ssd_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int COUNT_BITS    = 16;
    localparam int SAMPLE_PORT_W = 24;
    localparam int STD_W         = 24;
    localparam int COUNT_PORT_W  = 16;

    localparam int SQR_W  = 2 * SAMPLE_BITS;
    localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
    localparam int MAG_W  = SUM_W - 1;
    localparam int SQ_W   = 2 * SAMPLE_BITS - 2 + COUNT_BITS;
    localparam int PROD_W = SQ_W + COUNT_BITS;
    localparam int ACC_W  = PROD_W + 1;
    localparam int DIV_W  = 2 * COUNT_BITS;
    localparam int VAR_W  = (PROD_W < 64) ? PROD_W : 64;
    localparam int ROOT_W = VAR_W / 2;
    localparam int WIDE_W = 64;
    localparam int STEP_W = $clog2(PROD_W + 1);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [QPTR_W-1:0] QLAST_PTR = QPTR_W'(QDEPTH - 1);
    localparam logic [QCNT_W:0]   QFULL     = (QCNT_W + 1)'(QDEPTH);

    localparam logic [STEP_W-1:0] LAST_MUL_N = STEP_W'(COUNT_BITS - 1);
    localparam logic [STEP_W-1:0] LAST_MUL_S = STEP_W'(MAG_W - 1);
    localparam logic [STEP_W-1:0] LAST_DIV   = STEP_W'(PROD_W - 1);
    localparam logic [STEP_W-1:0] LAST_SQRT  = STEP_W'(ROOT_W - 1);

    localparam logic [WIDE_W-1:0] STD_MAX = (64'd1 << STD_W) - 64'd1;

    typedef struct packed {
        logic [COUNT_BITS-1:0]   count;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sumsq;
        logic                    ovf;
    } t_set;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_N,
        ST_MUL_S,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } t_back_state;

endpackage

@@ rtl/ssd_front.sv @@
// Front end: squares each sample, accumulates count, sum and sum of squares, closes sets.
module ssd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic [ssd_pkg::SAMPLE_PORT_W-1:0]   i_sample,
    input  logic                                i_last,
    input  logic [ssd_pkg::QCNT_W-1:0]          i_q_cnt,
    output logic                                o_full,
    output logic                                o_q_push,
    output ssd_pkg::t_set                       o_q_data
);

    logic                                 accept;
    logic [ssd_pkg::SAMPLE_BITS-1:0]      x_in;
    logic [ssd_pkg::SAMPLE_BITS-1:0]      mag_in;
    logic [ssd_pkg::SQR_W-1:0]            sq_in;
    logic [ssd_pkg::QCNT_W:0]             fill;
    logic                                 at_limit;

    logic                                 r_vld;
    logic                                 r_last;
    logic [ssd_pkg::SAMPLE_BITS-1:0]      r_x;
    logic [ssd_pkg::SQR_W-1:0]            r_sq;

    logic [ssd_pkg::COUNT_BITS-1:0]       r_cnt, n_cnt;
    logic signed [ssd_pkg::SUM_W-1:0]     r_sum, n_sum;
    logic [ssd_pkg::SQ_W-1:0]             r_sumsq, n_sumsq;
    logic                                 r_ovf, n_ovf;

    // A set closing in the accumulate stage needs a queue slot, so it counts as taken.
    assign fill   = {1'b0, i_q_cnt} + {{ssd_pkg::QCNT_W{1'b0}}, o_q_push};
    assign o_full = (fill >= ssd_pkg::QFULL);
    assign accept = i_push && !o_full;

    assign x_in   = i_sample[ssd_pkg::SAMPLE_BITS-1:0];
    assign mag_in = x_in[ssd_pkg::SAMPLE_BITS-1] ? (~x_in + 1'b1) : x_in;
    assign sq_in  = {{ssd_pkg::SAMPLE_BITS{1'b0}}, mag_in}
                  * {{ssd_pkg::SAMPLE_BITS{1'b0}}, mag_in};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_last <= 1'b0;
        end else begin
            r_vld  <= accept;
            r_last <= accept && i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x  <= x_in;
            r_sq <= sq_in;
        end
    end

    assign at_limit = (r_cnt == '1);

    always_comb begin
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        n_sumsq = r_sumsq;
        n_ovf   = r_ovf;
        if (r_vld) begin
            if (!at_limit) begin
                n_cnt   = r_cnt + 1'b1;
                n_sum   = r_sum + {{ssd_pkg::COUNT_BITS{r_x[ssd_pkg::SAMPLE_BITS-1]}}, r_x};
                n_sumsq = r_sumsq
                        + {{(ssd_pkg::SQ_W - ssd_pkg::SQR_W){1'b0}}, r_sq};
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    assign o_q_push       = r_vld && r_last;
    assign o_q_data.count = n_cnt;
    assign o_q_data.sum   = n_sum;
    assign o_q_data.sumsq = n_sumsq;
    assign o_q_data.ovf   = n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_q_push) begin
            r_cnt   <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            r_sumsq <= n_sumsq;
            r_ovf   <= n_ovf;
        end
    end

endmodule

@@ rtl/ssd_queue.sv @@
// Short queue of closed sets between the accumulating front end and the arithmetic back end.
module ssd_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  ssd_pkg::t_set              i_data,
    input  logic                       i_pop,
    output logic                       o_empty,
    output ssd_pkg::t_set              o_head,
    output logic [ssd_pkg::QCNT_W-1:0] o_cnt
);

    ssd_pkg::t_set                r_mem [ssd_pkg::QDEPTH];
    logic [ssd_pkg::QPTR_W-1:0]   r_wr, n_wr;
    logic [ssd_pkg::QPTR_W-1:0]   r_rd, n_rd;
    logic [ssd_pkg::QCNT_W-1:0]   r_cnt, n_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign o_cnt   = r_cnt;

    assign n_wr = (r_wr == ssd_pkg::QLAST_PTR) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == ssd_pkg::QLAST_PTR) ? '0 : r_rd + 1'b1;

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ rtl/ssd_back.sv @@
// Back end: shift-add numerator, restoring divide, digit-by-digit square root, result register.
module ssd_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_empty,
    input  ssd_pkg::t_set                     i_q_head,
    output logic                              o_q_pop,
    input  logic                              i_pop,
    output logic                              o_empty,
    output logic [ssd_pkg::STD_W-1:0]         o_std_dev,
    output logic [ssd_pkg::COUNT_PORT_W-1:0]  o_sample_count,
    output logic                              o_overflowed
);

    ssd_pkg::t_back_state r_state, n_state;

    logic [ssd_pkg::STEP_W-1:0]        r_step, n_step;
    logic signed [ssd_pkg::ACC_W-1:0]  r_acc, n_acc;
    logic [ssd_pkg::PROD_W-1:0]        r_mcand, n_mcand;
    logic [ssd_pkg::MAG_W-1:0]         r_mplier, n_mplier;
    logic [ssd_pkg::MAG_W-1:0]         r_mag, n_mag;
    logic [ssd_pkg::DIV_W-1:0]         r_div, n_div;
    logic [ssd_pkg::DIV_W-1:0]         r_rem, n_rem;
    logic [ssd_pkg::PROD_W-1:0]        r_quo, n_quo;
    logic [ssd_pkg::VAR_W-1:0]         r_rad, n_rad;
    logic [ssd_pkg::ROOT_W+1:0]        r_srem, n_srem;
    logic [ssd_pkg::ROOT_W-1:0]        r_root, n_root;
    logic [ssd_pkg::COUNT_BITS-1:0]    r_cnt, n_cnt;
    logic                              r_ovf, n_ovf;
    logic                              r_small, n_small;

    logic                              r_res_vld;
    logic [ssd_pkg::STD_W-1:0]         r_res_sd;
    logic [ssd_pkg::COUNT_PORT_W-1:0]  r_res_cnt;
    logic                              r_res_ovf;

    logic                              res_free;
    logic                              load_res;
    logic                              step_last;
    logic [ssd_pkg::WIDE_W-1:0]        root_wide;
    logic [31:0]                       cnt_wide;

    assign res_free = !r_res_vld || i_pop;

    always_comb begin
        unique case (r_state)
            ssd_pkg::ST_MUL_N: step_last = (r_step == ssd_pkg::LAST_MUL_N);
            ssd_pkg::ST_MUL_S: step_last = (r_step == ssd_pkg::LAST_MUL_S);
            ssd_pkg::ST_DIV:   step_last = (r_step == ssd_pkg::LAST_DIV);
            ssd_pkg::ST_SQRT:  step_last = (r_step == ssd_pkg::LAST_SQRT);
            default:           step_last = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssd_pkg::ST_IDLE:  if (!i_q_empty) n_state = ssd_pkg::ST_MUL_N;
            ssd_pkg::ST_MUL_N: if (step_last)  n_state = ssd_pkg::ST_MUL_S;
            ssd_pkg::ST_MUL_S: if (step_last)  n_state = ssd_pkg::ST_DIV;
            ssd_pkg::ST_DIV:   if (step_last)  n_state = ssd_pkg::ST_SQRT;
            ssd_pkg::ST_SQRT:  if (step_last)  n_state = ssd_pkg::ST_DONE;
            ssd_pkg::ST_DONE:  if (res_free)   n_state = ssd_pkg::ST_IDLE;
            default:           n_state = ssd_pkg::ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_q_pop  = 1'b0;
        load_res = 1'b0;
        unique case (r_state)
            ssd_pkg::ST_IDLE: o_q_pop  = !i_q_empty;
            ssd_pkg::ST_DONE: load_res = res_free;
            default: begin
                o_q_pop  = 1'b0;
                load_res = 1'b0;
            end
        endcase
    end

    // Datapath: one add, subtract or compare per cycle.
    always_comb begin
        logic [ssd_pkg::SUM_W-1:0]       sum_abs;
        logic signed [ssd_pkg::ACC_W-1:0] acc_nx;
        logic [ssd_pkg::DIV_W:0]         dshift;
        logic [ssd_pkg::DIV_W:0]         dsub;
        logic                            dge;
        logic [ssd_pkg::PROD_W-1:0]      quo_nx;
        logic [ssd_pkg::ROOT_W+3:0]      trem;
        logic [ssd_pkg::ROOT_W+3:0]      trial;
        logic [ssd_pkg::ROOT_W+3:0]      sdiff;
        logic                            sge;

        n_step   = r_step + 1'b1;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_mag    = r_mag;
        n_div    = r_div;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_rad    = r_rad;
        n_srem   = r_srem;
        n_root   = r_root;
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        n_small  = r_small;

        sum_abs = i_q_head.sum[ssd_pkg::SUM_W-1] ? (~i_q_head.sum + 1'b1) : i_q_head.sum;
        acc_nx  = r_acc;
        dshift  = {r_rem, r_quo[ssd_pkg::PROD_W-1]};
        dsub    = dshift - {1'b0, r_div};
        dge     = (dshift >= {1'b0, r_div});
        quo_nx  = {r_quo[ssd_pkg::PROD_W-2:0], dge};
        trem    = {r_srem, r_rad[ssd_pkg::VAR_W-1:ssd_pkg::VAR_W-2]};
        trial   = {2'b00, r_root, 2'b01};
        sdiff   = trem - trial;
        sge     = (trem >= trial);

        if (step_last) begin
            n_step = '0;
        end

        unique case (r_state)
            ssd_pkg::ST_IDLE: begin
                n_step = '0;
                if (!i_q_empty) begin
                    n_cnt    = i_q_head.count;
                    n_ovf    = i_q_head.ovf;
                    n_small  = (i_q_head.count[ssd_pkg::COUNT_BITS-1:1] == '0);
                    n_acc    = '0;
                    n_mcand  = {{(ssd_pkg::PROD_W - ssd_pkg::SQ_W){1'b0}}, i_q_head.sumsq};
                    n_mplier = {{(ssd_pkg::MAG_W - ssd_pkg::COUNT_BITS){1'b0}},
                                i_q_head.count};
                    n_mag    = sum_abs[ssd_pkg::MAG_W-1:0];
                    n_div    = {{ssd_pkg::COUNT_BITS{1'b0}}, i_q_head.count}
                             * {{ssd_pkg::COUNT_BITS{1'b0}}, i_q_head.count - 1'b1};
                end
            end
            ssd_pkg::ST_MUL_N: begin
                // Adds n times the sum of squares.
                if (r_mplier[0]) begin
                    n_acc = r_acc + {1'b0, r_mcand};
                end
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                if (step_last) begin
                    n_mcand  = {{(ssd_pkg::PROD_W - ssd_pkg::MAG_W){1'b0}}, r_mag};
                    n_mplier = r_mag;
                end
            end
            ssd_pkg::ST_MUL_S: begin
                // Subtracts the square of the sum.
                if (r_mplier[0]) begin
                    acc_nx = r_acc - {1'b0, r_mcand};
                end
                n_acc    = acc_nx;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                if (step_last) begin
                    n_rem = '0;
                    n_quo = acc_nx[ssd_pkg::ACC_W-1] ? '0 : acc_nx[ssd_pkg::PROD_W-1:0];
                end
            end
            ssd_pkg::ST_DIV: begin
                n_rem = dge ? dsub[ssd_pkg::DIV_W-1:0] : dshift[ssd_pkg::DIV_W-1:0];
                n_quo = quo_nx;
                if (step_last) begin
                    n_rad  = quo_nx[ssd_pkg::VAR_W-1:0];
                    n_srem = '0;
                    n_root = '0;
                end
            end
            ssd_pkg::ST_SQRT: begin
                n_srem = sge ? sdiff[ssd_pkg::ROOT_W+1:0] : trem[ssd_pkg::ROOT_W+1:0];
                n_root = {r_root[ssd_pkg::ROOT_W-2:0], sge};
                n_rad  = r_rad << 2;
            end
            ssd_pkg::ST_DONE: begin
                n_step = '0;
            end
            default: begin
                n_step = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssd_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_mag    <= n_mag;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_rad    <= n_rad;
        r_srem   <= n_srem;
        r_root   <= n_root;
        r_cnt    <= n_cnt;
        r_ovf    <= n_ovf;
        r_small  <= n_small;
    end

    assign root_wide = {{(ssd_pkg::WIDE_W - ssd_pkg::ROOT_W){1'b0}}, r_root};
    assign cnt_wide  = {{(32 - ssd_pkg::COUNT_BITS){1'b0}}, r_cnt};

    // A result may be taken in the same cycle that the next one is loaded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (load_res) begin
            r_res_vld <= 1'b1;
        end else if (i_pop) begin
            r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_res) begin
            if (r_small) begin
                r_res_sd <= '0;
            end else if (root_wide > ssd_pkg::STD_MAX) begin
                r_res_sd <= '1;
            end else begin
                r_res_sd <= root_wide[ssd_pkg::STD_W-1:0];
            end
            r_res_cnt <= cnt_wide[ssd_pkg::COUNT_PORT_W-1:0];
            r_res_ovf <= r_ovf;
        end
    end

    assign o_empty        = !r_res_vld;
    assign o_std_dev      = r_res_sd;
    assign o_sample_count = r_res_cnt;
    assign o_overflowed   = r_res_ovf;

endmodule

@@ rtl/sample_std_deviation.sv @@
// Sample standard deviation: one sample beat per cycle, one result beat per closed set.
// Samples are taken every cycle while full is low; the front end needs a queue slot per set.
// A closed set passes from the accumulators into the queue; the back end takes one set at a time
// through its shift-add multiply, restoring divide and square-root steps.
// Reset is synchronous and active low; it empties the queue and clears the accumulators.
module sample_std_deviation (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [ssd_pkg::SAMPLE_PORT_W-1:0]   i_sample,
    input  logic                                i_last,
    output logic                                empty,
    input  logic                                pop,
    output logic [ssd_pkg::STD_W-1:0]           o_std_dev,
    output logic [ssd_pkg::COUNT_PORT_W-1:0]    o_sample_count,
    output logic                                o_overflowed
);

    logic                        q_push;
    ssd_pkg::t_set               q_data;
    logic                        q_pop;
    logic                        q_empty;
    ssd_pkg::t_set               q_head;
    logic [ssd_pkg::QCNT_W-1:0]  q_cnt;
    logic                        res_pop;

    assign res_pop = pop && !empty;

    ssd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_sample (i_sample),
        .i_last   (i_last),
        .i_q_cnt  (q_cnt),
        .o_full   (full),
        .o_q_push (q_push),
        .o_q_data (q_data)
    );

    ssd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_data),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head),
        .o_cnt   (q_cnt)
    );

    ssd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_head       (q_head),
        .o_q_pop        (q_pop),
        .i_pop          (res_pop),
        .o_empty        (empty),
        .o_std_dev      (o_std_dev),
        .o_sample_count (o_sample_count),
        .o_overflowed   (o_overflowed)
    );

endmodule
